// ----- rtl/bitfield_cell_neighbour_generator_assert.svh -----
// Assertion macros used by the neighbour generator checker.
`ifndef BITFIELD_CELL_NEIGHBOUR_GENERATOR_ASSERT_SVH
`define BITFIELD_CELL_NEIGHBOUR_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCNG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCNG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after reset is applied.
`define BCNG_ASSERT_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bcng_pkg.sv -----
// Types, constants and elaboration helpers for the neighbour generator.
`timescale 1ns / 1ps

package bcng_pkg;

    localparam int ID_W     = 64;
    localparam int LAYOUT_W = 14;
    localparam int NCFG     = 3;
    localparam int FMAX     = 4;
    localparam int PDATA_W  = 64;
    localparam int PADDR_W  = 6;

    typedef enum logic [2:0] {
        REG_LAYOUT0 = 3'd0,
        REG_LAYOUT1 = 3'd1,
        REG_LAYOUT2 = 3'd2,
        REG_BOUNDS0 = 3'd3,
        REG_BOUNDS1 = 3'd4,
        REG_BOUNDS2 = 3'd5,
        REG_DIAG    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [NCFG-1:0][LAYOUT_W-1:0] layout;
        logic [NCFG-1:0][63:0]         bounds;
        logic                          diag;
    } t_cfg;

    // Bound comparisons of one field value, taken in the first front stage.
    typedef struct packed {
        logic le_lo;
        logic gt_hip1;
        logic ge_hi;
        logic lt_lom1;
    } t_cmp;

    // Everything the back end needs to apply a step of one field.
    typedef struct packed {
        logic [ID_W-1:0] clr;
        logic [ID_W-1:0] vm;
        logic [ID_W-1:0] vp;
        logic            okm;
        logic            okp;
    } t_fstep;

    // One neighbour candidate: which fields move and in which direction.
    typedef struct packed {
        logic [FMAX-1:0] fmask;
        logic [FMAX-1:0] fplus;
    } t_entry;

    function automatic logic [ID_W-1:0] f_fmask(input logic [5:0] wm1);
        return {ID_W{1'b1}} >> (6'd63 - wm1);
    endfunction

    function automatic logic [ID_W-1:0] f_sext32(input logic [31:0] b);
        return {{32{b[31]}}, b};
    endfunction

    function automatic int f_num_entries(input int nf);
        int p;
        p = 1;
        for (int i = 0; i < nf; i++) p = p * 3;
        return p - 1;
    endfunction

    // Candidate number e in emission order: single-field steps first, then the
    // combinations from all fields down to pairs with their sign patterns.
    function automatic t_entry f_entry(input int nf, input int e);
        t_entry r;
        int     n;
        int     pc;
        int     cnt;
        r = '0;
        n = 2 * nf;
        if (e < 2 * nf) begin
            r.fmask[e >> 1] = 1'b1;
            r.fplus[e >> 1] = e[0];
        end else begin
            for (int k = nf; k > 1; k--) begin
                for (int v = (1 << nf) - 1; v >= 0; v--) begin
                    pc = 0;
                    for (int f = 0; f < nf; f++) pc = pc + ((v >> f) & 1);
                    if (pc == k) begin
                        for (int p = 0; p < (1 << k); p++) begin
                            if (n == e) begin
                                cnt = 0;
                                for (int f = 0; f < nf; f++) begin
                                    if (((v >> (nf - 1 - f)) & 1) == 1) begin
                                        r.fmask[f] = 1'b1;
                                        r.fplus[f] = (((p >> (k - 1 - cnt)) & 1) == 1);
                                        cnt = cnt + 1;
                                    end
                                end
                            end
                            n = n + 1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/bitfield_cell_neighbour_generator.sv -----
// Top level of the neighbour generator: configuration registers and the two ends.
`timescale 1ns / 1ps

// Generates the identifiers of the cells around a packed cell identifier.
// Input words are pushed with push while full is low; results are read with
// pop while empty is low, oldest first, one per cycle at most.
// Each cell word gives one result per neighbour in emission order; the last
// carries o_is_last. A cell without neighbours gives one result with
// o_found low, o_neighbour_id zero and o_is_last high.
// Configuration goes through the APB port at byte address 8*index; it may
// only be written while no word is in flight.
// A word passes the front stage register and the queue; its first result then
// goes to the result register once the invalid candidates ahead are skipped.
// The back end checks one candidate per cycle, holding at a valid one while
// the result is not taken, and stops at the last valid one: it walks at most
// 3**NUM_FIELDS-1 candidates with diagonals on (26 for three fields) and
// 2*NUM_FIELDS without; a word with no neighbour gives its result without a walk.
// The front end and a two-entry queue accept further words meanwhile.
// When pop is held low the result register holds and the back end stops at
// its next valid candidate; the front fills the queue and then raises full.
// Reset clears the pipeline, the queue and all configuration registers.
module bitfield_cell_neighbour_generator #(
    parameter int NUM_FIELDS = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bcng_pkg::PADDR_W-1:0]    paddr,
    input  logic [bcng_pkg::PDATA_W-1:0]    pwdata,
    output logic [bcng_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            push,
    output logic                            full,
    input  logic [bcng_pkg::ID_W-1:0]       i_cell_id,
    output logic                            empty,
    input  logic                            pop,
    output logic [bcng_pkg::ID_W-1:0]       o_neighbour_id,
    output logic                            o_found,
    output logic                            o_is_last
);

    import bcng_pkg::*;

    localparam int QW    = ID_W + NUM_FIELDS * $bits(t_fstep);
    localparam int QDEPTH = 2;

    logic [LAYOUT_W-1:0] r_layout [NCFG];
    logic [63:0]         r_bounds [NCFG];
    logic                r_diag;
    t_cfg                cfg;
    logic                cfg_wr;
    logic [2:0]          reg_sel;

    logic                          f_wr;
    logic                          q_full, q_empty, q_rd;
    logic [ID_W-1:0]               f_cell;
    t_fstep [NUM_FIELDS-1:0]       f_steps;
    logic [QW-1:0]                 q_wdata, q_rdata;
    logic [ID_W-1:0]               b_base;
    t_fstep [NUM_FIELDS-1:0]       b_steps;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCFG; i++) begin
                r_layout[i] <= '0;
                r_bounds[i] <= '0;
            end
            r_diag <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_LAYOUT0: r_layout[0] <= pwdata[LAYOUT_W-1:0];
                REG_LAYOUT1: r_layout[1] <= pwdata[LAYOUT_W-1:0];
                REG_LAYOUT2: r_layout[2] <= pwdata[LAYOUT_W-1:0];
                REG_BOUNDS0: r_bounds[0] <= pwdata;
                REG_BOUNDS1: r_bounds[1] <= pwdata;
                REG_BOUNDS2: r_bounds[2] <= pwdata;
                REG_DIAG:    r_diag      <= pwdata[0];
                default:     r_diag      <= r_diag;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_LAYOUT0: prdata = PDATA_W'(r_layout[0]);
            REG_LAYOUT1: prdata = PDATA_W'(r_layout[1]);
            REG_LAYOUT2: prdata = PDATA_W'(r_layout[2]);
            REG_BOUNDS0: prdata = r_bounds[0];
            REG_BOUNDS1: prdata = r_bounds[1];
            REG_BOUNDS2: prdata = r_bounds[2];
            REG_DIAG:    prdata = PDATA_W'(r_diag);
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < NCFG; i++) begin
            cfg.layout[i] = r_layout[i];
            cfg.bounds[i] = r_bounds[i];
        end
        cfg.diag = r_diag;
    end

    bcng_front #(
        .NUM_FIELDS (NUM_FIELDS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_push    (push),
        .i_cell_id (i_cell_id),
        .o_full    (full),
        .o_wr      (f_wr),
        .i_q_full  (q_full),
        .o_cell    (f_cell),
        .o_steps   (f_steps)
    );

    assign q_wdata = {f_cell, f_steps};

    bcng_queue #(
        .W     (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_wr),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    assign b_base  = q_rdata[QW-1 -: ID_W];
    assign b_steps = q_rdata[QW-ID_W-1:0];

    bcng_back #(
        .NUM_FIELDS (NUM_FIELDS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_diag         (r_diag),
        .i_q_empty      (q_empty),
        .i_base         (b_base),
        .i_steps        (b_steps),
        .o_q_rd         (q_rd),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_neighbour_id (o_neighbour_id),
        .o_found        (o_found),
        .o_is_last      (o_is_last)
    );

endmodule

// ----- rtl/bcng_queue.sv -----
// Short register queue between the front and back ends.
`timescale 1ns / 1ps

module bcng_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_rd,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (wr_en) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/bcng_front.sv -----
// Front end: takes cell words, reads the fields and works out every field step.
`timescale 1ns / 1ps

module bcng_front #(
    parameter int NUM_FIELDS = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bcng_pkg::t_cfg                         i_cfg,
    input  logic                                   i_push,
    input  logic [bcng_pkg::ID_W-1:0]              i_cell_id,
    output logic                                   o_full,
    output logic                                   o_wr,
    input  logic                                   i_q_full,
    output logic [bcng_pkg::ID_W-1:0]              o_cell,
    output bcng_pkg::t_fstep [NUM_FIELDS-1:0]      o_steps
);

    import bcng_pkg::*;

    logic            r_a_vld, n_a_vld;
    logic [ID_W-1:0] r_a_cell;
    logic [ID_W-1:0] r_a_raw [NUM_FIELDS];
    t_cmp            r_a_cmp [NUM_FIELDS];
    logic [ID_W-1:0] n_a_raw [NUM_FIELDS];
    t_cmp            n_a_cmp [NUM_FIELDS];
    logic            a_load;

    // The stage register only waits when the queue is full.
    assign o_wr   = r_a_vld && !i_q_full;
    assign o_full = r_a_vld && i_q_full;
    assign a_load = i_push && !o_full;
    assign o_cell = r_a_cell;

    always_comb begin
        n_a_vld = r_a_vld;
        if (a_load) begin
            n_a_vld = 1'b1;
        end else if (o_wr) begin
            n_a_vld = 1'b0;
        end
    end

    for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_fld
        logic [LAYOUT_W-1:0] lay;
        logic [63:0]         bnd;
        logic [5:0]          off;
        logic [5:0]          wm1;
        logic                sgn;
        logic                cyc;
        logic [ID_W-1:0]     mask;
        logic [ID_W-1:0]     raw;
        logic [ID_W-1:0]     key;
        logic signed [65:0]  k66;
        logic signed [65:0]  lo66;
        logic signed [65:0]  hi66;
        logic [ID_W-1:0]     lo64;
        logic [ID_W-1:0]     hi64;
        logic [ID_W-1:0]     nvm;
        logic [ID_W-1:0]     nvp;

        // Fields without registers keep the reset layout and bounds.
        if (f < NCFG) begin : g_cfg
            assign lay = i_cfg.layout[f];
            assign bnd = i_cfg.bounds[f];
        end else begin : g_rst
            assign lay = '0;
            assign bnd = '0;
        end

        assign off  = lay[5:0];
        assign wm1  = lay[11:6];
        assign sgn  = lay[12];
        assign cyc  = lay[13];
        assign mask = f_fmask(wm1);
        assign lo64 = f_sext32(bnd[31:0]);
        assign hi64 = f_sext32(bnd[63:32]);

        // First stage: extract the field and compare it against its bounds.
        always_comb begin
            raw = (i_cell_id >> off) & mask;
            if (sgn) begin
                key = raw[wm1] ? (raw | ~mask) : raw;
            end else begin
                key = raw[63] ? {1'b0, {(ID_W-1){1'b1}}} : raw;
            end
            k66  = {{2{key[63]}}, key};
            lo66 = {{2{lo64[63]}}, lo64};
            hi66 = {{2{hi64[63]}}, hi64};
            n_a_raw[f]         = raw;
            n_a_cmp[f].le_lo   = (k66 <= lo66);
            n_a_cmp[f].gt_hip1 = (k66 > (hi66 + 66'sd1));
            n_a_cmp[f].ge_hi   = (k66 >= hi66);
            n_a_cmp[f].lt_lom1 = (k66 < (lo66 - 66'sd1));
        end

        // Second stage: new field values for both directions, placed in the word.
        always_comb begin
            nvm = r_a_raw[f] - ID_W'(1);
            nvp = r_a_raw[f] + ID_W'(1);
            if (cyc) begin
                if (r_a_cmp[f].le_lo) begin
                    nvm = hi64;
                end else if (r_a_cmp[f].gt_hip1) begin
                    nvm = lo64;
                end
                if (r_a_cmp[f].ge_hi) begin
                    nvp = lo64;
                end else if (r_a_cmp[f].lt_lom1) begin
                    nvp = hi64;
                end
            end
            o_steps[f].clr = mask << off;
            o_steps[f].vm  = (nvm & mask) << off;
            o_steps[f].vp  = (nvp & mask) << off;
            o_steps[f].okm = cyc || !r_a_cmp[f].le_lo;
            o_steps[f].okp = cyc || !r_a_cmp[f].ge_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= n_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_cell <= i_cell_id;
            for (int f = 0; f < NUM_FIELDS; f++) begin
                r_a_raw[f] <= n_a_raw[f];
                r_a_cmp[f] <= n_a_cmp[f];
            end
        end
    end

endmodule

// ----- rtl/bcng_back.sv -----
// Back end: walks the neighbour candidates of the queue head, one per cycle while results are taken.
`timescale 1ns / 1ps

module bcng_back #(
    parameter int NUM_FIELDS = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_diag,
    input  logic                                   i_q_empty,
    input  logic [bcng_pkg::ID_W-1:0]              i_base,
    input  bcng_pkg::t_fstep [NUM_FIELDS-1:0]      i_steps,
    output logic                                   o_q_rd,
    output logic                                   o_empty,
    input  logic                                   i_pop,
    output logic [bcng_pkg::ID_W-1:0]              o_neighbour_id,
    output logic                                   o_found,
    output logic                                   o_is_last
);

    import bcng_pkg::*;

    localparam int NE      = f_num_entries(NUM_FIELDS);
    localparam int NSINGLE = 2 * NUM_FIELDS;
    localparam int IW      = (NE > 1) ? $clog2(NE) : 1;

    logic [NUM_FIELDS-1:0] ent_fmask [NE];
    logic [NUM_FIELDS-1:0] ent_fplus [NE];
    logic [NE-1:0]         ent_valid;
    logic [NUM_FIELDS-1:0] okm, okp;
    logic [NUM_FIELDS-1:0] cur_fmask, cur_fplus;
    logic [ID_W-1:0]       cand;
    logic                  any, last, adv, load;
    logic [ID_W-1:0]       res_id;
    logic                  res_found, res_last;

    logic [IW-1:0]   r_idx, n_idx;
    logic            r_out_vld, n_out_vld;
    logic [ID_W-1:0] r_nid;
    logic            r_found, r_last;

    always_comb begin
        for (int f = 0; f < NUM_FIELDS; f++) begin
            okm[f] = i_steps[f].okm;
            okp[f] = i_steps[f].okp;
        end
    end

    // A candidate is valid when every field it moves can take its step; multi-field candidates also need diag.
    for (genvar e = 0; e < NE; e++) begin : g_ent
        localparam t_entry C = f_entry(NUM_FIELDS, e);
        logic [NUM_FIELDS-1:0] sel;
        logic                  all_ok;

        assign ent_fmask[e] = C.fmask[NUM_FIELDS-1:0];
        assign ent_fplus[e] = C.fplus[NUM_FIELDS-1:0];
        assign sel    = (C.fplus[NUM_FIELDS-1:0] & okp) | (~C.fplus[NUM_FIELDS-1:0] & okm);
        assign all_ok = &(~C.fmask[NUM_FIELDS-1:0] | sel);
        if (e < NSINGLE) begin : g_single
            assign ent_valid[e] = all_ok;
        end else begin : g_diag
            assign ent_valid[e] = all_ok && i_diag;
        end
    end

    assign cur_fmask = ent_fmask[r_idx];
    assign cur_fplus = ent_fplus[r_idx];
    assign any       = |ent_valid;
    assign last      = ~|((ent_valid >> r_idx) >> 1);
    assign adv       = !r_out_vld || i_pop;

    // Later fields win where fields overlap.
    always_comb begin
        cand = i_base;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            if (cur_fmask[f]) begin
                cand = (cand & ~i_steps[f].clr) | (cur_fplus[f] ? i_steps[f].vp : i_steps[f].vm);
            end
        end
    end

    always_comb begin
        n_idx     = r_idx;
        load      = 1'b0;
        o_q_rd    = 1'b0;
        res_id    = cand;
        res_found = 1'b1;
        res_last  = last;
        priority if (i_q_empty) begin
            n_idx = r_idx;
        end else if (!any) begin
            if (adv) begin
                load      = 1'b1;
                res_id    = '0;
                res_found = 1'b0;
                res_last  = 1'b1;
                o_q_rd    = 1'b1;
                n_idx     = '0;
            end
        end else if (ent_valid[r_idx]) begin
            if (adv) begin
                load = 1'b1;
                if (last) begin
                    o_q_rd = 1'b1;
                    n_idx  = '0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
        end else begin
            n_idx = r_idx + IW'(1);
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (load) begin
            n_out_vld = 1'b1;
        end else if (i_pop && r_out_vld) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_nid   <= res_id;
            r_found <= res_found;
            r_last  <= res_last;
        end
    end

    assign o_empty        = !r_out_vld;
    assign o_neighbour_id = r_nid;
    assign o_found        = r_found;
    assign o_is_last      = r_last;

endmodule

// ----- rtl/bcng_checker.sv -----
// Port-level checks of the neighbour generator, bound to its top level.
`timescale 1ns / 1ps

`include "bitfield_cell_neighbour_generator_assert.svh"

module bcng_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic [bcng_pkg::ID_W-1:0] o_neighbour_id,
    input logic                      o_found,
    input logic                      o_is_last
);

    logic        stalled;
    logic        miss;
    logic [65:0] out_word;

    assign stalled  = !empty && !pop;
    assign miss     = !empty && !o_found;
    assign out_word = {o_neighbour_id, o_found, o_is_last};

    // After reset nothing is waiting and a word can be taken at once.
    `BCNG_ASSERT_RESET(a_reset_idle, i_clk, i_rst_n, empty && !full, "not idle after reset")

    // A word that reports a missing neighbour must carry o_is_last.
    `BCNG_ASSERT_SAME(a_none_last, i_clk, i_rst_n, miss, o_is_last, "no-neighbour word not last")

    `BCNG_ASSERT_SAME(a_none_zero, i_clk, i_rst_n, miss, o_neighbour_id == '0, "no-neighbour word not zero")

    `BCNG_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, stalled, !empty && $stable(out_word), "stalled word changed")

endmodule

bind bitfield_cell_neighbour_generator bcng_checker u_bcng_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_neighbour_id (o_neighbour_id),
    .o_found        (o_found),
    .o_is_last      (o_is_last)
);
